// File: sv/olist_pkg.sv
// Shared constants and controller/datapath interface types for the ordered list block.
package olist_pkg;

    // Field widths of the request and result words
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;

    // Default list capacity
    localparam int CAPACITY_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                load;        // capture request, rewind scan pointer
        logic                step;        // issue next read, advance pipeline
        logic                seek;        // restart pointer just above the hit
        logic                shift_wr;    // write fetched entry one place down
        logic                append_wr;   // write key at tail, bump count
        logic                dec_count;   // drop one entry from the count
        logic                set_res;     // load result registers
        logic [STATUS_W-1:0] res_status;
        logic                res_hit_pos; // position from hit index, else zero
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;      // captured operation
        logic            hit;     // fetched entry equals key
        logic            drained; // nothing fetched and nothing left to fetch
        logic            full;    // count at capacity
    } t_dp_stat;

endpackage

// File: sv/ordered_list_append_search_delete_top.sv
// Top level of the ordered list with append, search and compacting delete.
//
//  channel   | handshake        | words
//  ----------+------------------+--------------------------------------------
//  request   | start / busy     | i_operation, i_value
//  result    | o_valid strobe   | o_status, o_position, o_entry_count
//
// One request at a time. Append and the unused code go from accept through an
// execute state to the result strobe; search scans from the head until a hit or
// the last entry; delete then moves every entry above the hit one place down.
// The pace is set by the single read port of the entry memory, which the scan
// and the shift walk one entry a cycle.
// Reset is synchronous and clears the count; entries are read only below it.
// The result strobe lasts one cycle and cannot be held off; busy falls the
// cycle after it.
module ordered_list_append_search_delete_top #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [olist_pkg::OP_W-1:0]     i_operation,
    input  logic signed [olist_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    output logic        [olist_pkg::STATUS_W-1:0] o_status,
    output logic        [olist_pkg::POS_W-1:0]    o_position,
    output logic        [olist_pkg::CNT_W-1:0]    o_entry_count
);
    import olist_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    olist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    olist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    // No result in the cycle right after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result strobe right after accept");

    // Strobe lasts one cycle and the block then returns to idle
    a_strobe_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("block not idle after result");

    // A miss or a full list never reports a position
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL))
        |-> (o_position == '0))
        else $error("position reported without a match");

    // Strobe only while the block is busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

endmodule

// File: sv/olist_dp.sv
// Datapath: entry memory, scan/shift read pipeline, count and result registers.
module olist_dp #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic        [olist_pkg::OP_W-1:0]    i_operation,
    input  logic signed [olist_pkg::VALUE_W-1:0] i_value,
    input  olist_pkg::t_dp_cmd                   i_cmd,
    output olist_pkg::t_dp_stat                  o_stat,
    output logic        [olist_pkg::STATUS_W-1:0] o_status,
    output logic        [olist_pkg::POS_W-1:0]   o_position,
    output logic        [olist_pkg::CNT_W-1:0]   o_entry_count
);
    import olist_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry store
    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [OP_W-1:0]     r_op;
    logic [VALUE_W-1:0]  r_key;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic                r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]       r_cmp_idx, n_cmp_idx;
    logic [VALUE_W-1:0]  r_rdata;
    logic [STATUS_W-1:0] r_status;
    logic [IW-1:0]       r_pos;

    logic                rd_en;
    logic                we;
    logic [IW-1:0]       waddr;
    logic [VALUE_W-1:0]  wdata;

    // Read only below the count
    assign rd_en = i_cmd.step && (r_ptr < r_count);

    // Single write port: tail append or compaction move
    assign we    = i_cmd.append_wr || (i_cmd.shift_wr && r_cmp_vld);
    assign waddr = i_cmd.append_wr ? r_count[IW-1:0] : (r_cmp_idx - IW'(1));
    assign wdata = i_cmd.append_wr ? r_key : r_rdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_ptr[IW-1:0]];
        end
    end

    // Pointer and read pipeline tracking
    always_comb begin
        n_ptr     = r_ptr;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        priority if (i_cmd.load) begin
            n_ptr     = '0;
            n_cmp_vld = 1'b0;
        end else if (i_cmd.seek) begin
            n_ptr     = CW'(r_cmp_idx) + CW'(1);
            n_cmp_vld = 1'b0;
        end else if (i_cmd.step) begin
            n_cmp_vld = rd_en;
            if (rd_en) begin
                n_cmp_idx = r_ptr[IW-1:0];
                n_ptr     = r_ptr + CW'(1);
            end
        end else begin
            n_ptr = r_ptr;
        end
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.append_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec_count) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= i_value;
        end
        if (i_cmd.set_res) begin
            r_status <= i_cmd.res_status;
            r_pos    <= i_cmd.res_hit_pos ? r_cmp_idx : '0;
        end
    end

    // Status to controller
    assign o_stat.op      = r_op;
    assign o_stat.hit     = r_cmp_vld && (r_rdata == r_key);
    assign o_stat.drained = !r_cmp_vld && (r_ptr >= r_count);
    assign o_stat.full    = (r_count >= CW'(CAPACITY));

    // Result word, masked or extended to field widths
    assign o_status = r_status;

    generate
        if (IW >= POS_W) begin : g_pos_trunc
            assign o_position = r_pos[POS_W-1:0];
        end else begin : g_pos_ext
            assign o_position = {{(POS_W-IW){1'b0}}, r_pos};
        end
        if (CW >= CNT_W) begin : g_cnt_trunc
            assign o_entry_count = r_count[CNT_W-1:0];
        end else begin : g_cnt_ext
            assign o_entry_count = {{(CNT_W-CW){1'b0}}, r_count};
        end
    endgenerate

endmodule

// File: sv/olist_ctrl.sv
// Controller: sequences append, scan, compaction and the result strobe.
module olist_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_valid,
    input  olist_pkg::t_dp_stat i_stat,
    output olist_pkg::t_dp_cmd  o_cmd
);
    import olist_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state, n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.op == OP_APPEND) begin
                    o_cmd.set_res = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.res_status = ST_OK;
                        o_cmd.append_wr  = 1'b1;
                    end
                    n_state = S_RESP;
                end else if (i_stat.op == OP_SEARCH || i_stat.op == OP_DELETE) begin
                    n_state = S_SCAN;
                end else begin
                    // unused code: report ok, nothing changes
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_RESP;
                end
            end
            S_SCAN: begin
                priority if (i_stat.hit) begin
                    o_cmd.set_res     = 1'b1;
                    o_cmd.res_status  = ST_OK;
                    o_cmd.res_hit_pos = 1'b1;
                    if (i_stat.op == OP_DELETE) begin
                        o_cmd.seek = 1'b1;
                        n_state    = S_SHIFT;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (i_stat.drained) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.drained) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.step     = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESP);

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the ordered list block: directed and random requests.
module testbench;
    import olist_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    entry_count;
    } t_list_result;

    // Shadow copy of the list plus the queue of results still owed by the block
    class t_olist_shadow;
        logic [VALUE_W-1:0] store [LIST_CAP];
        int                 held;
        t_list_result       owed [$];
        int                 mismatches;
        int                 checked;
        int                 n_append, n_search, n_delete, n_unused;
        int                 n_full, n_miss, peak;

        function new();
            held = 0;
            mismatches = 0;
            checked = 0;
            n_append = 0;
            n_search = 0;
            n_delete = 0;
            n_unused = 0;
            n_full = 0;
            n_miss = 0;
            peak = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its result
        function void log_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
            t_list_result r;
            int hit;
            r.status = ST_OK;
            r.position = '0;
            hit = -1;
            case (op)
                OP_APPEND: begin
                    n_append++;
                    if (held >= LIST_CAP) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        store[held] = val;
                        held++;
                    end
                end
                OP_SEARCH, OP_DELETE: begin
                    if (op == OP_SEARCH) n_search++;
                    else n_delete++;
                    for (int i = 0; i < held; i++) begin
                        if (hit < 0 && store[i] == val) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                        n_miss++;
                    end else begin
                        r.position = hit[POS_W-1:0];
                        if (op == OP_DELETE) begin
                            // compact: later entries slide down one slot
                            for (int i = hit; i + 1 < held; i++) store[i] = store[i+1];
                            held--;
                        end
                    end
                end
                default: n_unused++;
            endcase
            if (held > peak) peak = held;
            r.entry_count = held[CNT_W-1:0];
            owed.push_back(r);
        endfunction

        // Compare one strobed result against the oldest owed one
        function void check_result(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
                                   logic [CNT_W-1:0] cnt);
            t_list_result e;
            checked++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result status=%0d position=%0d count=%0d",
                             st, pos, cnt);
                return;
            end
            e = owed.pop_front();
            if (st !== e.status || pos !== e.position || cnt !== e.entry_count) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"ERROR: result %0d: expected status=%0d position=%0d ",
                              "count=%0d, got status=%0d position=%0d count=%0d"},
                             checked, e.status, e.position, e.entry_count, st, pos, cnt);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Mostly values already held so search and delete hit, plus corners and noise
        function logic [VALUE_W-1:0] pick_value();
            int r;
            r = $urandom_range(99);
            if (r < 55 && held > 0) return store[$urandom_range(held - 1, 0)];
            if (r < 75) begin
                case ($urandom_range(5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0000;
                    default: return $urandom_range(7);
                endcase
            end
            return $urandom;
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic        [OP_W-1:0]     i_operation = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic        [STATUS_W-1:0] o_status;
    logic        [POS_W-1:0]    o_position;
    logic        [CNT_W-1:0]    o_entry_count;

    t_olist_shadow list_model;
    int            idle_pct;
    int            quiet_cycles = 0;

    ordered_list_append_search_delete_top #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result monitor: outputs are read at the edge that accepts them
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) list_model.check_result(o_status, o_position, o_entry_count);
    end

    // Watchdog on cycles where no word moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
                $display("** ordered_list_append_search_delete_top: FAILED **");
                $finish;
            end
        end
    end

    // Present one request, idling first at the current rate, and wait for accept
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_value <= val;
        do @(posedge i_clk); while (busy);
        list_model.log_request(op, val);
    endtask

    // Hold off until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (list_model.pending() != 0) @(posedge i_clk);
    endtask

    // Random requests biased to fill the list to full, then empty it again
    task automatic random_requests(input int n);
        bit filling;
        int r;
        logic [OP_W-1:0] op;
        filling = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (filling && list_model.held >= LIST_CAP && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (!filling && list_model.held == 0 && $urandom_range(2) == 0)
                filling = 1'b1;
            else if ($urandom_range(49) == 0)
                filling = !filling;
            r = $urandom_range(99);
            if (filling)
                op = (r < 65) ? OP_APPEND : (r < 80) ? OP_SEARCH : (r < 95) ? OP_DELETE
                                                                             : OP_UNUSED;
            else
                op = (r < 15) ? OP_APPEND : (r < 35) ? OP_SEARCH : (r < 95) ? OP_DELETE
                                                                             : OP_UNUSED;
            send_request(op, list_model.pick_value());
        end
    endtask

    initial begin
        list_model = new();
        idle_pct = 15;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, extreme values, duplicates, head/tail delete, unused code
        send_request(OP_SEARCH, 32'h0000_0005);
        send_request(OP_DELETE, 32'h0000_0005);
        send_request(OP_UNUSED, 32'h0000_0000);
        send_request(OP_APPEND, 32'h8000_0000);
        send_request(OP_APPEND, 32'h7FFF_FFFF);
        send_request(OP_APPEND, 32'h0000_0000);
        send_request(OP_APPEND, 32'hFFFF_FFFF);
        send_request(OP_APPEND, 32'h7FFF_FFFF);
        send_request(OP_APPEND, 32'h5555_5555);
        send_request(OP_APPEND, 32'hAAAA_AAAA);
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'h7FFF_FFFE);
        send_request(OP_SEARCH, 32'h1234_5678);
        send_request(OP_DELETE, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        send_request(OP_DELETE, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        send_request(OP_DELETE, 32'hAAAA_AAAA);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'hAAAA_AAAA);
        drain_results();

        // Random phases: light sender gaps, heavy gaps, then back to back
        random_requests(RANDOM_ITEMS / 3);
        drain_results();
        idle_pct = 70;
        random_requests(RANDOM_ITEMS / 3);
        drain_results();
        idle_pct = 0;
        random_requests(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        drain_results();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d appends, %0d searches, %0d deletes, %0d unused-code requests;",
                 list_model.n_append, list_model.n_search, list_model.n_delete,
                 list_model.n_unused);
        $display("%0d results checked, %0d full drops, %0d misses, peak fill %0d of %0d.",
                 list_model.checked, list_model.n_full, list_model.n_miss,
                 list_model.peak, LIST_CAP);
        if (list_model.mismatches == 0 && list_model.pending() == 0) begin
            $display("** ordered_list_append_search_delete_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", list_model.mismatches,
                     list_model.pending());
            $display("** ordered_list_append_search_delete_top: FAILED **");
        end
        $finish;
    end

endmodule
